### rtl/ggvc_pkg.sv
package ggvc_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = 17;
    localparam int HEAD_W  = 13;
    localparam int SUM_W   = 33;
    localparam int ROOT_W  = 17;
    localparam int CXY_W   = 35;  // CORDIC x/y: 17 bit offset << 16, plus gain growth
    localparam int ANG_W   = 20;  // bearing, rad Q.16
    localparam int ERR_W   = 21;  // bearing minus heading
    localparam int ATAN_LEN = 24;

    localparam logic signed [ANG_W-1:0] ANG_PI     = 20'sd205887;
    localparam logic signed [ERR_W-1:0] ERR_PI     = 21'sd205887;
    localparam logic signed [ERR_W-1:0] ERR_TWO_PI = 21'sd411774;

    localparam logic [15:0] SPEED_GAIN_RST    = 16'd6144;
    localparam logic [15:0] STEER_GAIN_RST    = 16'd18432;
    localparam logic [14:0] SPEED_LIMIT_RST   = 15'd2048;
    localparam logic [14:0] STEER_LIMIT_RST   = 15'd2048;
    localparam logic [14:0] ARRIVE_RADIUS_RST = 15'd102;

    typedef enum logic [2:0] {
        CFG_GOAL_X        = 3'd0,
        CFG_GOAL_Y        = 3'd1,
        CFG_SPEED_GAIN    = 3'd2,
        CFG_STEER_GAIN    = 3'd3,
        CFG_SPEED_LIMIT   = 3'd4,
        CFG_STEER_LIMIT   = 3'd5,
        CFG_ARRIVE_RADIUS = 3'd6
    } cfg_reg_t;

    // atan(2^-i) in rad Q.16
    function automatic logic signed [ANG_W-1:0] atan_at(input int idx);
        logic signed [ANG_W-1:0] a;
        begin
            case (idx)
                0:       a = 20'sd51472;
                1:       a = 20'sd30385;
                2:       a = 20'sd16054;
                3:       a = 20'sd8150;
                4:       a = 20'sd4091;
                5:       a = 20'sd2047;
                6:       a = 20'sd1024;
                7:       a = 20'sd512;
                8:       a = 20'sd256;
                9:       a = 20'sd128;
                10:      a = 20'sd64;
                11:      a = 20'sd32;
                12:      a = 20'sd16;
                13:      a = 20'sd8;
                14:      a = 20'sd4;
                15:      a = 20'sd2;
                16:      a = 20'sd1;
                default: a = 20'sd0;
            endcase
            return a;
        end
    endfunction

endpackage

### rtl/go_to_goal_velocity_controller_top.sv
// Go-to-goal velocity controller.
// Input channel: one pose beat (pos_x, pos_y, heading) per accepted cycle,
// taken when in_valid is high and in_stall low. Output channel: one command
// beat (linear_speed, turn_rate, reached) per input beat, in order.
// Config: write cfg_data to register cfg_index when cfg_valid is high; ready
// is always high. Write only while no beat is in flight.
// The 17 stage square root and the CORDIC bearing chain run side by side
// and are aligned by delay lines.
// Throughput: one beat per cycle while no finished beat is held under stall.
// All stages share one advance enable: the pipe moves unless a finished beat
// sits at the output under stall. Then every stage holds and in_stall is
// raised, so nothing is dropped or repeated.
// Reset clears all valid bits and loads the default registers (goal at the
// origin, gains 1.5 / 4.5, limits 2.0, reach radius 0.1).
// Reached beats carry zero speeds.
module go_to_goal_velocity_controller_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [12:0] heading,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [14:0]        linear_speed,
    output logic signed [15:0] turn_rate,
    output logic               reached,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int DW   = ggvc_pkg::DIFF_W;
    localparam int HW   = ggvc_pkg::HEAD_W;
    localparam int SW   = ggvc_pkg::SUM_W;
    localparam int RW   = ggvc_pkg::ROOT_W;
    localparam int XW   = ggvc_pkg::CXY_W;
    localparam int ZW   = ggvc_pkg::ANG_W;
    localparam int EW   = ggvc_pkg::ERR_W;
    // both units finish at stage E
    localparam int SQRT_END = 3 + RW;
    localparam int CORD_END = 2 + CORDIC_STAGES;
    localparam int E   = (SQRT_END > CORD_END) ? SQRT_END : CORD_END;
    localparam int LAT = E + 4;

    // ---------------- config registers ----------------
    logic signed [15:0] goal_x_reg, goal_y_reg;
    logic [15:0]        speed_gain_reg, steer_gain_reg;
    logic [14:0]        speed_limit_reg, steer_limit_reg, arrive_radius_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg        <= '0;
            goal_y_reg        <= '0;
            speed_gain_reg    <= ggvc_pkg::SPEED_GAIN_RST;
            steer_gain_reg    <= ggvc_pkg::STEER_GAIN_RST;
            speed_limit_reg   <= ggvc_pkg::SPEED_LIMIT_RST;
            steer_limit_reg   <= ggvc_pkg::STEER_LIMIT_RST;
            arrive_radius_reg <= ggvc_pkg::ARRIVE_RADIUS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (ggvc_pkg::cfg_reg_t'(cfg_index))
                ggvc_pkg::CFG_GOAL_X:        goal_x_reg        <= cfg_data;
                ggvc_pkg::CFG_GOAL_Y:        goal_y_reg        <= cfg_data;
                ggvc_pkg::CFG_SPEED_GAIN:    speed_gain_reg    <= cfg_data;
                ggvc_pkg::CFG_STEER_GAIN:    steer_gain_reg    <= cfg_data;
                ggvc_pkg::CFG_SPEED_LIMIT:   speed_limit_reg   <= cfg_data[14:0];
                ggvc_pkg::CFG_STEER_LIMIT:   steer_limit_reg   <= cfg_data[14:0];
                ggvc_pkg::CFG_ARRIVE_RADIUS: arrive_radius_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic           en;
    logic [LAT:1]   v_reg;

    assign en        = !(v_reg[LAT] && out_stall);
    assign in_stall  = !en;
    assign out_valid = v_reg[LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[LAT-1:1], in_valid};
    end

    // ---------------- stage 1: offsets ----------------
    logic signed [DW-1:0] dx1_reg, dy1_reg, dx1_next, dy1_next;
    logic                 zero1_next;

    assign dx1_next   = DW'(goal_x_reg) - DW'(pos_x);
    assign dy1_next   = DW'(goal_y_reg) - DW'(pos_y);
    assign zero1_next = (dx1_next == '0) && (dy1_next == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg <= dx1_next;
            dy1_reg <= dy1_next;
        end
    end

    // heading and zero-offset flag ride along to stage E
    logic [HW:0] hz_e;
    ggvc_delay #(.WIDTH(HW + 1), .DEPTH(E)) u_hz_dly (
        .clk (clk),
        .en  (en),
        .d   ({zero1_next, heading}),
        .q   (hz_e)
    );

    // ---------------- stage 2: squares, quadrant fold ----------------
    logic [31:0]          dxsq2_reg, dysq2_reg;
    logic [29:0]          rsq2_reg;
    logic signed [XW-1:0] x2_reg, y2_reg;
    logic signed [ZW-1:0] z2_reg, z2_next;
    logic signed [2*DW-1:0] dxsq_full, dysq_full;
    logic signed [DW-1:0] xa, ya;
    logic                 neg1;

    assign dxsq_full = dx1_reg * dx1_reg;
    assign dysq_full = dy1_reg * dy1_reg;
    assign neg1      = dx1_reg[DW-1];
    assign xa        = neg1 ? -dx1_reg : dx1_reg;
    assign ya        = neg1 ? -dy1_reg : dy1_reg;

    always_comb
    begin
        if (!neg1)
            z2_next = '0;
        else if (!dy1_reg[DW-1])
            z2_next = ggvc_pkg::ANG_PI;
        else
            z2_next = -ggvc_pkg::ANG_PI;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxsq2_reg <= dxsq_full[31:0];
            dysq2_reg <= dysq_full[31:0];
            rsq2_reg  <= arrive_radius_reg * arrive_radius_reg;
            x2_reg    <= {{(XW-DW-16){xa[DW-1]}}, xa, 16'b0};
            y2_reg    <= {{(XW-DW-16){ya[DW-1]}}, ya, 16'b0};
            z2_reg    <= z2_next;
        end
    end

    // ---------------- stage 3: sum, reach test ----------------
    logic [SW-1:0] sum3_reg, sum3_next;
    logic          reached3_next;

    assign sum3_next     = SW'(dxsq2_reg) + SW'(dysq2_reg);
    assign reached3_next = sum3_next < SW'(rsq2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
            sum3_reg <= sum3_next;
    end

    logic reached_e;
    ggvc_delay #(.WIDTH(1), .DEPTH(E - 2)) u_reach_dly (
        .clk (clk),
        .en  (en),
        .d   (reached3_next),
        .q   (reached_e)
    );

    // ---------------- square root and bearing ----------------
    logic [RW-1:0]        root_u, dist_e;
    logic signed [ZW-1:0] bear_u, bear_e;

    ggvc_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (sum3_reg),
        .root     (root_u)
    );

    ggvc_delay #(.WIDTH(RW), .DEPTH(E - SQRT_END)) u_root_dly (
        .clk (clk),
        .en  (en),
        .d   (root_u),
        .q   (dist_e)
    );

    ggvc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .clk   (clk),
        .en    (en),
        .x_in  (x2_reg),
        .y_in  (y2_reg),
        .z_in  (z2_reg),
        .z_out (bear_u)
    );

    ggvc_delay #(.WIDTH(ZW), .DEPTH(E - CORD_END)) u_bear_dly (
        .clk (clk),
        .en  (en),
        .d   (bear_u),
        .q   (bear_e)
    );

    // ---------------- stage E+1: raw error, speed product ----------------
    logic signed [EW-1:0] err1_reg, head64, bear_x;
    logic [32:0]          linp1_reg;
    logic                 reached1_reg;

    assign head64 = {{(EW-HW-6){hz_e[HW-1]}}, hz_e[HW-1:0], 6'b0};
    // zero offset: bearing taken as 0
    assign bear_x = hz_e[HW] ? '0 : EW'(bear_e);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err1_reg     <= bear_x - head64;
            linp1_reg    <= speed_gain_reg * dist_e;
            reached1_reg <= reached_e;
        end
    end

    // ---------------- stage E+2: wrap, speed round and clamp ----------------
    logic signed [EW-1:0] err2_reg, err2_next;
    logic [14:0]          lin2_reg, lin2_next;
    logic [33:0]          lin_round;
    logic [21:0]          lin_sh;
    logic                 reached2_reg;

    always_comb
    begin
        if (err1_reg > ggvc_pkg::ERR_PI)
            err2_next = err1_reg - ggvc_pkg::ERR_TWO_PI;
        else if (err1_reg < -ggvc_pkg::ERR_PI)
            err2_next = err1_reg + ggvc_pkg::ERR_TWO_PI;
        else
            err2_next = err1_reg;
    end

    assign lin_round = 34'(linp1_reg) + 34'd2048;
    assign lin_sh    = lin_round[33:12];
    assign lin2_next = (lin_sh > 22'(speed_limit_reg)) ? speed_limit_reg : lin_sh[14:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err2_reg     <= err2_next;
            lin2_reg     <= lin2_next;
            reached2_reg <= reached1_reg;
        end
    end

    // ---------------- stage E+3: turn product ----------------
    logic signed [37:0] turnp3_reg;
    logic [14:0]        lin3_reg;
    logic               reached3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            turnp3_reg   <= $signed({1'b0, steer_gain_reg}) * err2_reg;
            lin3_reg     <= lin2_reg;
            reached3_reg <= reached2_reg;
        end
    end

    // ---------------- stage E+4: turn round, clamp, output ----------------
    logic signed [37:0] turn_round;
    logic signed [19:0] turn_sh, lim20, turn_next;
    logic [14:0]        linear_speed_reg;
    logic signed [15:0] turn_rate_reg;
    logic               reached_reg;

    assign turn_round = turnp3_reg + 38'sd131072;
    assign turn_sh    = turn_round[37:18];
    assign lim20      = $signed({5'b0, steer_limit_reg});

    always_comb
    begin
        if (turn_sh > lim20)
            turn_next = lim20;
        else if (turn_sh < -lim20)
            turn_next = -lim20;
        else
            turn_next = turn_sh;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            linear_speed_reg <= reached3_reg ? '0 : lin3_reg;
            turn_rate_reg    <= reached3_reg ? '0 : turn_next[15:0];
            reached_reg      <= reached3_reg;
        end
    end

    assign linear_speed = linear_speed_reg;
    assign turn_rate    = turn_rate_reg;
    assign reached      = reached_reg;

    // ---------------- assertions ----------------
    a_reached_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reached |-> linear_speed == '0 && turn_rate == '0)
        else $error("reached beat with nonzero speed");

    a_speed_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> linear_speed <= speed_limit_reg)
        else $error("linear speed above limit");

    a_turn_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> turn_rate <= $signed({1'b0, steer_limit_reg}) &&
                      turn_rate >= -$signed({1'b0, steer_limit_reg}))
        else $error("turn rate outside limit");

    a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[E+2] |-> err2_reg <= ggvc_pkg::ERR_PI && err2_reg >= -ggvc_pkg::ERR_PI)
        else $error("heading error not wrapped");

endmodule

### rtl/ggvc_delay.sv
module ggvc_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    generate
        if (DEPTH == 0) begin : g_none
            assign q = d;
        end else begin : g_line
            logic [WIDTH-1:0] tap_reg [DEPTH];
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tap_reg[0] <= d;
                    for (int i = 1; i < DEPTH; i++)
                    begin
                        tap_reg[i] <= tap_reg[i-1];
                    end
                end
            end
            assign q = tap_reg[DEPTH-1];
        end
    endgenerate

endmodule

### rtl/ggvc_isqrt.sv
// one root bit per stage, MSB first; remainder kept as n - root^2
module ggvc_isqrt (
    input  logic                          clk,
    input  logic                          en,
    input  logic [ggvc_pkg::SUM_W-1:0]    radicand,
    output logic [ggvc_pkg::ROOT_W-1:0]   root
);

    localparam int SW = ggvc_pkg::SUM_W;
    localparam int RW = ggvc_pkg::ROOT_W;
    localparam int DW = 2 * RW + 1;

    logic [SW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];

    generate
        for (genvar k = 0; k < RW; k++) begin : g_stage
            localparam int B = RW - 1 - k;
            logic [SW-1:0] rem_in;
            logic [RW-1:0] root_in;
            logic [DW-1:0] delta;
            logic [DW-1:0] rem_ext;

            if (k == 0) begin : g_first
                assign rem_in  = radicand;
                assign root_in = '0;
            end else begin : g_next
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
            end

            assign delta   = (DW'(root_in) << (B + 1)) + (DW'(1) << (2 * B));
            assign rem_ext = DW'(rem_in);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (rem_ext >= delta)
                    begin
                        rem_reg[k]  <= SW'(rem_ext - delta);
                        root_reg[k] <= root_in | (RW'(1) << B);
                    end
                    else
                    begin
                        rem_reg[k]  <= rem_in;
                        root_reg[k] <= root_in;
                    end
                end
            end
        end
    endgenerate

    assign root = root_reg[RW-1];

endmodule

### rtl/ggvc_cordic.sv
// vectoring CORDIC, one micro-rotation per stage
module ggvc_cordic #(
    parameter int STAGES = 16
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [ggvc_pkg::CXY_W-1:0]  x_in,
    input  logic signed [ggvc_pkg::CXY_W-1:0]  y_in,
    input  logic signed [ggvc_pkg::ANG_W-1:0]  z_in,
    output logic signed [ggvc_pkg::ANG_W-1:0]  z_out
);

    localparam int XW = ggvc_pkg::CXY_W;
    localparam int ZW = ggvc_pkg::ANG_W;

    logic signed [XW-1:0] x_reg [STAGES];
    logic signed [XW-1:0] y_reg [STAGES];
    logic signed [ZW-1:0] z_reg [STAGES];

    generate
        for (genvar i = 0; i < STAGES; i++) begin : g_stage
            logic signed [XW-1:0] xi, yi, xs, ys;
            logic signed [ZW-1:0] zi, a;

            if (i == 0) begin : g_first
                assign xi = x_in;
                assign yi = y_in;
                assign zi = z_in;
            end else begin : g_next
                assign xi = x_reg[i-1];
                assign yi = y_reg[i-1];
                assign zi = z_reg[i-1];
            end

            assign xs = xi >>> i;
            assign ys = yi >>> i;
            assign a  = ggvc_pkg::atan_at(i);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (yi > 0)
                    begin
                        x_reg[i] <= xi + ys;
                        y_reg[i] <= yi - xs;
                        z_reg[i] <= zi + a;
                    end
                    else
                    begin
                        x_reg[i] <= xi - ys;
                        y_reg[i] <= yi + xs;
                        z_reg[i] <= zi - a;
                    end
                end
            end
        end
    endgenerate

    assign z_out = z_reg[STAGES-1];

endmodule

### tb/ggvc_checker.sv
module ggvc_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [12:0] heading,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [14:0]        linear_speed,
    input  logic signed [15:0] turn_rate,
    input  logic               reached,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [14:0]        lin;
        logic signed [15:0] turn;
        logic               hit;
    } command_t;

    localparam int STAGES = 16;
    localparam longint PI_Q16 = 205887;

    logic signed [15:0] gx, gy;
    logic [15:0] kv, kw;
    logic [14:0] vmax, wmax, radius;
    command_t cmd_q[$];

    assign pending = cmd_q.size();

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint n);
        longint r;
        r = 0;
        for (int b = 16; b >= 0; b--)
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n)
                r = r + (longint'(1) << b);
        return r;
    endfunction

    function automatic longint atan_q16(int i);
        longint t[17] = '{51472, 30385, 16054, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2, 1};
        return (i < 17) ? t[i] : 0;
    endfunction

    function automatic longint bearing_to_goal(longint dx, longint dy);
        longint x, y, z, xs, ys;
        z = 0;
        if (dx == 0 && dy == 0)
            return 0;
        if (dx < 0)
        begin
            x = -dx * 65536;
            y = -dy * 65536;
            z = (dy >= 0) ? PI_Q16 : -PI_Q16;
        end
        else
        begin
            x = dx * 65536;
            y = dy * 65536;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y > 0)
            begin
                x = x + ys; y = y - xs; z += atan_q16(i);
            end
            else
            begin
                x = x - ys; y = y + xs; z -= atan_q16(i);
            end
        end
        return z;
    endfunction

    function automatic command_t steer_toward_goal(logic signed [15:0] px,
                                                   logic signed [15:0] py,
                                                   logic signed [12:0] hd);
        command_t c;
        longint dx, dy, sum, err, lin, turn, lim;
        dx = longint'(gx) - longint'(px);
        dy = longint'(gy) - longint'(py);
        sum = dx * dx + dy * dy;
        c = '0;
        if (sum < longint'(radius) * longint'(radius))
        begin
            c.hit = 1'b1;
            return c;
        end
        err = bearing_to_goal(dx, dy) - longint'(hd) * 64;
        if (err > PI_Q16)
            err -= 2 * PI_Q16;
        else if (err < -PI_Q16)
            err += 2 * PI_Q16;
        lin = (longint'(kv) * root_floor(sum) + 2048) >>> 12;
        if (lin > longint'(vmax))
            lin = longint'(vmax);
        turn = shr_floor(longint'(kw) * err + (1 << 17), 18);
        lim = longint'(wmax);
        if (turn > lim) turn = lim;
        if (turn < -lim) turn = -lim;
        c.lin = lin[14:0];
        c.turn = turn[15:0];
        return c;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        command_t e;
        if (!rst_n)
        begin
            gx <= '0; gy <= '0;
            kv <= ggvc_pkg::SPEED_GAIN_RST; kw <= ggvc_pkg::STEER_GAIN_RST;
            vmax <= ggvc_pkg::SPEED_LIMIT_RST; wmax <= ggvc_pkg::STEER_LIMIT_RST;
            radius <= ggvc_pkg::ARRIVE_RADIUS_RST;
            fail_count <= 0;
            cmd_q.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                cmd_q.push_back(steer_toward_goal(pos_x, pos_y, heading));
            if (out_valid && !out_stall)
            begin
                if (cmd_q.size() == 0)
                begin
                    $display("%t: unexpected beat expected none actual %0d %0d %0d",
                             $realtime, linear_speed, turn_rate, reached);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = cmd_q.pop_front();
                    if (e.lin !== linear_speed || e.turn !== turn_rate
                        || e.hit !== reached)
                    begin
                        $display("%t: mismatch expected %0d %0d %0d actual %0d %0d %0d",
                                 $realtime, e.lin, e.turn, e.hit,
                                 linear_speed, turn_rate, reached);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                case (ggvc_pkg::cfg_reg_t'(cfg_index))
                    ggvc_pkg::CFG_GOAL_X:        gx <= cfg_data;
                    ggvc_pkg::CFG_GOAL_Y:        gy <= cfg_data;
                    ggvc_pkg::CFG_SPEED_GAIN:    kv <= cfg_data;
                    ggvc_pkg::CFG_STEER_GAIN:    kw <= cfg_data;
                    ggvc_pkg::CFG_SPEED_LIMIT:   vmax <= cfg_data[14:0];
                    ggvc_pkg::CFG_STEER_LIMIT:   wmax <= cfg_data[14:0];
                    ggvc_pkg::CFG_ARRIVE_RADIUS: radius <= cfg_data[14:0];
                    default: ;
                endcase
        end
    end
endmodule

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Drain allows slack after the checker queue empties.
    localparam int DRAIN_CYCLES = 40;
    // Idle-cycle watchdog: longest receiver stall plus pipe latency, many times over.
    localparam int WATCHDOG_LIMIT = 5000;
    // Register index past the end of the map
    localparam logic [2:0] CFG_IDX_UNUSED = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0, out_stall = 1'b0, cfg_valid = 1'b0;
    logic in_stall, out_valid, cfg_ready, reached;
    logic signed [15:0] pos_x = '0, pos_y = '0, turn_rate;
    logic signed [12:0] heading = '0;
    logic [14:0] linear_speed;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int fail_count, pending;
    int send_idle_pct, recv_idle_pct;
    int idle_cycles;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    go_to_goal_velocity_controller_top dut (.*);

    ggvc_checker u_checker (.*);

    // Receiver: stall at the current percentage, decided every edge.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // Watchdog on cycles with no accepted beat on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Send one pose beat; valid held until accepted, with random gaps first.
    // Valid stays up after the beat; the next send or drain takes it down.
    task automatic send_pose(logic signed [15:0] px, logic signed [15:0] py,
                             logic signed [12:0] hd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x <= px;
        pos_y <= py;
        heading <= hd;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Registers change only with the pipe empty and quiet.
    task automatic write_reg(ggvc_pkg::cfg_reg_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Offsets near the goal hit the reached branch; wide ones exercise clamps.
    task automatic random_pose();
        logic signed [15:0] px, py;
        logic signed [12:0] hd;
        case ($urandom_range(3))
            0:
            begin
                px = u_checker.gx;
                py = u_checker.gy;
                px = 16'(px + $signed(16'($urandom_range(300))) - 16'sd150);
                py = 16'(py + $signed(16'($urandom_range(300))) - 16'sd150);
            end
            default:
            begin
                px = 16'($urandom);
                py = 16'($urandom);
            end
        endcase
        // Mostly in-range headings; sometimes the full 13-bit field.
        hd = ($urandom_range(9) == 0) ? 13'($urandom)
                                      : 13'($signed($urandom_range(6434)) - 3217);
        send_pose(px, py, hd);
    endtask

    task automatic config_set(logic [15:0] x, logic [15:0] y, logic [15:0] kv,
                              logic [15:0] kw, logic [14:0] vm, logic [14:0] wm,
                              logic [14:0] r);
        write_reg(ggvc_pkg::CFG_GOAL_X, x);
        write_reg(ggvc_pkg::CFG_GOAL_Y, y);
        write_reg(ggvc_pkg::CFG_SPEED_GAIN, kv);
        write_reg(ggvc_pkg::CFG_STEER_GAIN, kw);
        write_reg(ggvc_pkg::CFG_SPEED_LIMIT, {1'b0, vm});
        write_reg(ggvc_pkg::CFG_STEER_LIMIT, {1'b0, wm});
        write_reg(ggvc_pkg::CFG_ARRIVE_RADIUS, {1'b0, r});
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        send_idle_pct = 6;
        recv_idle_pct = 71;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: defaults, goal at origin.
        send_pose(16'sd0, 16'sd0, 13'sd0);          // on the goal: reached
        send_pose(16'sd50, -16'sd50, 13'sd0);       // inside the radius
        send_pose(16'sd32767, 16'sd32767, 13'sd3217);
        send_pose(16'sh8000, 16'sh8000, -13'sd3217);
        send_pose(16'sh8000, 16'sd0, 13'sd0);       // bearing 0, widest x offset
        send_pose(16'sd0, -16'sd1024, 13'sd3217);   // heading +pi, bearing +pi/2
        send_pose(16'sd0, 16'sd1024, -13'sd3217);
        send_pose(16'sd1024, 16'sd0, 13'sd4095);    // heading beyond pi
        send_pose(-16'sd1024, 16'sd0, 13'sh1000);
        send_pose(16'sd102, 16'sd0, 13'sd0);        // exactly on the radius
        drain();

        // Zero radius, zero offset: bearing taken as 0; also max gains, max limits.
        config_set(16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 15'd0);
        send_pose(16'sh8000, 16'sd32767, 13'sd1000);
        send_pose(16'sd32767, 16'sh8000, -13'sd2000);
        send_pose(16'sd0, 16'sd0, 13'sd0);
        drain();
        // out-of-range index: ignored
        write_reg(ggvc_pkg::cfg_reg_t'(CFG_IDX_UNUSED), 16'hFFFF);
        config_set(16'sd0, 16'sd0, 16'd0, 16'd0, 15'd0, 15'd0, 15'h7FFF);
        send_pose(16'sd32767, 16'sd0, 13'sd0);      // max radius
        send_pose(16'sh8000, 16'sh8000, 13'sd100);
        send_pose(16'sd1, 16'sd1, 13'sd0);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 71 : 0;
            recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 6 : 0;
            for (int blk = 0; blk < 5; blk++)
            begin
                config_set(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                           15'($urandom), 15'($urandom), 15'($urandom_range(2000)));
                for (int n = 0; n < 110; n++)
                    random_pose();
                drain();
            end
        end
        config_set(16'sd0, 16'sd0, ggvc_pkg::SPEED_GAIN_RST, ggvc_pkg::STEER_GAIN_RST,
                   ggvc_pkg::SPEED_LIMIT_RST, ggvc_pkg::STEER_LIMIT_RST,
                   ggvc_pkg::ARRIVE_RADIUS_RST);
        send_pose(16'sd2048, -16'sd2048, 13'sd0);
        drain();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

### filelist.f
rtl/ggvc_pkg.sv
rtl/ggvc_delay.sv
rtl/ggvc_isqrt.sv
rtl/ggvc_cordic.sv
rtl/go_to_goal_velocity_controller_top.sv
tb/ggvc_checker.sv
tb/testbench.sv
